@@ design/sliding_window_median_filter_defines.svh @@
// assertion macros shared by the checker
`ifndef SLIDING_WINDOW_MEDIAN_FILTER_DEFINES_SVH
`define SLIDING_WINDOW_MEDIAN_FILTER_DEFINES_SVH

// a holds now, b holds at the same edge
`define SWMF_ASSERT_NOW(label, a, b) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) \
		else $error("swmf check failed");

// a holds now, b holds at the next edge
`define SWMF_ASSERT_NEXT(label, a, b) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) \
		else $error("swmf check failed");

`define SWMF_ASSERT_LATER2(label, a, b) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> ##2 (b)) \
		else $error("swmf check failed");

`endif

@@ design/swmf_pkg.sv @@
`timescale 1ns / 1ps

package swmf_pkg;

	localparam int WINDOW      = 8;
	localparam int SAMPLE_BITS = 16;

	// port widths fixed by the stream fields
	localparam int FIELD_BITS = 16;
	// stored bits: only the low SAMPLE_BITS of a sample matter
	localparam int VALUE_BITS = (SAMPLE_BITS < FIELD_BITS) ? SAMPLE_BITS : FIELD_BITS;
	localparam int TAG_BITS   = $clog2(WINDOW);
	// index of the reported entry once the window is full
	localparam int MID        = WINDOW / 2;

	typedef logic [VALUE_BITS-1:0] value_t;
	typedef logic [TAG_BITS-1:0]   tag_t;

	// contents of one cell of the sorted row
	typedef struct packed {
		logic   valid;
		value_t value;
		tag_t   tag;
	} cell_t;

	// per-cell compare results handed to both neighbors
	typedef struct packed {
		logic le;   // entry is valid and not above the new sample
		logic del;  // entry sits at or above the removed one
	} cell_flags_t;

	// values broadcast to every cell for one transfer
	typedef struct packed {
		logic   load;
		logic   full;
		value_t sample;
		tag_t   slot;
		value_t drop_value;
	} cell_bcast_t;

	// where a cell stands relative to the median index
	typedef struct packed {
		logic at_mid;
		logic below_mid;
	} cell_pos_t;

endpackage

@@ design/swmf_if.sv @@
`timescale 1ns / 1ps

// sample stream
interface swmf_sample_if;
	logic                             valid;
	logic                             ready;
	logic [swmf_pkg::FIELD_BITS-1:0] sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

// median stream
interface swmf_median_if;
	logic                             valid;
	logic                             ready;
	logic [swmf_pkg::FIELD_BITS-1:0] median;

	modport source (output valid, output median, input ready);
	modport sink   (input valid, input median, output ready);
endinterface

@@ design/swmf_cell.sv @@
`timescale 1ns / 1ps

module swmf_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  swmf_pkg::cell_bcast_t bcast,
	input  swmf_pkg::cell_pos_t   pos,
	input  swmf_pkg::cell_t       prv_cell,
	input  swmf_pkg::cell_flags_t prv_flags,
	input  swmf_pkg::cell_t       nxt_cell,
	input  swmf_pkg::cell_flags_t nxt_flags,
	output swmf_pkg::cell_t       cell_out,
	output swmf_pkg::cell_flags_t flags,
	output swmf_pkg::value_t      hit_value,
	output swmf_pkg::value_t      mid_value
);

	swmf_pkg::cell_t  cur;
	swmf_pkg::cell_t  cell_d;
	swmf_pkg::cell_t  pack_own;
	swmf_pkg::cell_t  pack_prv;
	swmf_pkg::cell_t  fresh;
	logic             valid_q;
	swmf_pkg::value_t value_q;
	swmf_pkg::tag_t   tag_q;
	logic             lp_own;
	logic             lp_prv;
	logic             hit;
	logic             is_mid;

	// stored entry as one word
	assign cur      = '{valid: valid_q, value: value_q, tag: tag_q};
	assign cell_out = cur;

	// local compares against the new sample and the removed value
	assign flags.le  = cur.valid && (cur.value <= bcast.sample);
	assign flags.del = bcast.full && cur.valid && (cur.value >= bcast.drop_value);

	// the oldest entry, whose value every cell needs for its removal compare
	assign hit       = bcast.full && cur.valid && (cur.tag == bcast.slot);
	assign hit_value = hit ? cur.value : '0;

	// median pick: fixed slot when full, top valid entry while filling
	assign is_mid    = cur.valid && (pos.at_mid || (pos.below_mid && !nxt_cell.valid));
	assign mid_value = is_mid ? cur.value : '0;

	// row after removal, at this slot and the one below
	always_comb begin
		pack_own = flags.del ? nxt_cell : cur;
		pack_prv = prv_flags.del ? cur : prv_cell;
		lp_own   = flags.del ? nxt_flags.le : flags.le;
		lp_prv   = prv_flags.del ? flags.le : prv_flags.le;
		fresh    = '{valid: 1'b1, value: bcast.sample, tag: bcast.slot};
	end

	// keep or close the gap from above, take the new sample, or shift up from below
	always_comb begin
		if (lp_own) begin
			cell_d = pack_own;
		end else if (lp_prv) begin
			cell_d = fresh;
		end else begin
			cell_d = pack_prv;
		end
		cell_d.valid = prv_cell.valid;
	end

	// occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (bcast.load) begin
			valid_q <= cell_d.valid;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (bcast.load) begin
			value_q <= cell_d.value;
			tag_q   <= cell_d.tag;
		end
	end

endmodule

@@ design/sliding_window_median_filter.sv @@
`timescale 1ns / 1ps

// Sliding-window median filter.
// samples: sink stream of unsigned samples; only the low SAMPLE_BITS bits
// are kept. medians: source stream with one result per sample, the sorted
// window entry at index min(WINDOW/2, count-1), the upper median for an
// even window, taken over the samples seen so far while the window fills.
// A transfer on samples updates the row of WINDOW compare-and-shift cells
// together: the oldest entry leaves, the new one drops in above any
// equal values. The result is then picked from the registered row into
// the output register as soon as that register is free to load, and it
// transfers once the receiver is ready.
// Throughput is one sample per cycle while the receiver takes every result;
// the cell update and the single output register set this figure.
// Reset empties the window and the ring position; no clearing pass is
// needed since each cell carries its own valid bit.
// When the receiver stalls, the result holds in the output register and
// one more sample may be taken; then ready drops until the result leaves.
module sliding_window_median_filter (
	input  logic          clk,
	input  logic          arst_n,
	swmf_sample_if.sink   samples,
	swmf_median_if.source medians
);

	localparam int W = swmf_pkg::WINDOW;

	swmf_pkg::cell_t       cells     [W];
	swmf_pkg::cell_flags_t cell_flags[W];
	swmf_pkg::value_t      hit_vals  [W];
	swmf_pkg::value_t      mid_vals  [W];
	swmf_pkg::cell_t       prv_cells [W];
	swmf_pkg::cell_flags_t prv_flags [W];
	swmf_pkg::cell_t       nxt_cells [W];
	swmf_pkg::cell_flags_t nxt_flags [W];

	swmf_pkg::cell_bcast_t bcast;
	swmf_pkg::tag_t        slot_q;
	swmf_pkg::value_t      drop_value;
	swmf_pkg::value_t      pick_value;
	swmf_pkg::value_t      median_q;
	logic                  pend_q;
	logic                  out_valid_q;
	logic                  can_load;
	logic                  in_xfer;

	// handshake
	assign can_load       = !out_valid_q || medians.ready;
	assign samples.ready  = !pend_q || can_load;
	assign in_xfer        = samples.valid && samples.ready;
	assign medians.valid  = out_valid_q;
	assign medians.median = swmf_pkg::FIELD_BITS'(median_q);

	// value of the oldest entry and the median pick, one-hot merges
	always_comb begin
		drop_value = '0;
		pick_value = '0;
		for (int i = 0; i < W; i++) begin
			drop_value = drop_value | hit_vals[i];
			pick_value = pick_value | mid_vals[i];
		end
	end

	// broadcast to the cell row
	always_comb begin
		bcast.load       = in_xfer;
		bcast.full       = cells[W-1].valid;
		bcast.sample     = samples.sample[swmf_pkg::VALUE_BITS-1:0];
		bcast.slot       = slot_q;
		bcast.drop_value = drop_value;
	end

	// row of cells, each wired to both neighbors
	for (genvar i = 0; i < W; i++) begin : g_cell
		swmf_pkg::cell_pos_t pos;

		assign pos.at_mid    = (i == swmf_pkg::MID);
		assign pos.below_mid = (i < swmf_pkg::MID);

		if (i == 0) begin : g_first
			assign prv_cells[i] = '{valid: 1'b1, value: '0, tag: '0};
			assign prv_flags[i] = '{le: 1'b1, del: 1'b0};
		end else begin : g_inner_lo
			assign prv_cells[i] = cells[i-1];
			assign prv_flags[i] = cell_flags[i-1];
		end

		if (i == W - 1) begin : g_last
			assign nxt_cells[i] = '{valid: 1'b0, value: '0, tag: '0};
			assign nxt_flags[i] = '{le: 1'b0, del: 1'b0};
		end else begin : g_inner_hi
			assign nxt_cells[i] = cells[i+1];
			assign nxt_flags[i] = cell_flags[i+1];
		end

		swmf_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.bcast     (bcast),
			.pos       (pos),
			.prv_cell  (prv_cells[i]),
			.prv_flags (prv_flags[i]),
			.nxt_cell  (nxt_cells[i]),
			.nxt_flags (nxt_flags[i]),
			.cell_out  (cells[i]),
			.flags     (cell_flags[i]),
			.hit_value (hit_vals[i]),
			.mid_value (mid_vals[i])
		);
	end

	// ring slot of the next sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (in_xfer) begin
			slot_q <= (slot_q == swmf_pkg::tag_t'(W - 1)) ? '0 : slot_q + 1'b1;
		end
	end

	// result pending and output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_xfer) begin
				pend_q <= 1'b1;
			end else if (can_load) begin
				pend_q <= 1'b0;
			end
			if (pend_q && can_load) begin
				out_valid_q <= 1'b1;
			end else if (medians.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (pend_q && can_load) begin
			median_q <= pick_value;
		end
	end

endmodule

@@ design/swmf_checker.sv @@
`timescale 1ns / 1ps
`include "sliding_window_median_filter_defines.svh"

module swmf_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_ready,
	input logic [swmf_pkg::FIELD_BITS-1:0] sample,
	input logic                            out_valid,
	input logic                            out_ready,
	input logic [swmf_pkg::FIELD_BITS-1:0] median
);

	logic in_xfer;

	assign in_xfer = in_valid && in_ready;

	// a stalled result holds its value
	`SWMF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(median))

	// every sample transfer has a result on show after the cell row and the output register
	`SWMF_ASSERT_LATER2(a_result_follows, in_xfer, out_valid)

	// an empty output register never blocks the input
	`SWMF_ASSERT_NOW(a_ready_when_idle, !out_valid, in_ready)

	// a transferred sample carries no unknown bits
	`SWMF_ASSERT_NOW(a_sample_known, in_xfer, !$isunknown(sample))

endmodule

bind sliding_window_median_filter swmf_checker u_swmf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (samples.valid),
	.in_ready  (samples.ready),
	.sample    (samples.sample),
	.out_valid (medians.valid),
	.out_ready (medians.ready),
	.median    (medians.median)
);

@@ verif/sliding_window_median_checker.sv @@
`timescale 1ns / 1ps

// watches both streams, tracks the sorted window and checks every median in order
module sliding_window_median_checker (
	input  logic   clk,
	input  logic   arst_n,
	swmf_sample_if samples,
	swmf_median_if medians,
	output int     mismatches,
	output int     medians_seen,
	output int     medians_owed
);

	typedef logic [swmf_pkg::FIELD_BITS-1:0] word_t;

	// only the low SAMPLE_BITS of a sample take part
	localparam word_t SAMPLE_MASK =
		{swmf_pkg::FIELD_BITS{1'b1}} >> (swmf_pkg::FIELD_BITS - swmf_pkg::VALUE_BITS);

	// window contents in ascending order, each with the ring slot it came in on
	word_t       win_value [swmf_pkg::WINDOW];
	int unsigned win_slot  [swmf_pkg::WINDOW];
	int unsigned win_fill;
	int unsigned next_slot;

	// medians predicted for accepted samples, oldest first
	word_t owed_q [$];
	word_t oldest;

	// slide one sample into the window and return the median it produces
	function automatic word_t slide_window(input word_t raw);
		word_t       v;
		int unsigned drop_at;
		int unsigned pos;
		int unsigned pick;
		int unsigned i;
		v = raw & SAMPLE_MASK;
		// full window: the entry that arrived on this ring slot leaves
		if (win_fill == swmf_pkg::WINDOW) begin
			drop_at = win_fill - 1;
			for (i = 0; i < win_fill; i++) begin
				if (win_slot[i] == next_slot) begin
					drop_at = i;
					break;
				end
			end
			for (i = drop_at; i + 1 < win_fill; i++) begin
				win_value[i] = win_value[i + 1];
				win_slot[i]  = win_slot[i + 1];
			end
			win_fill--;
		end
		// new sample lands above every entry not greater than it
		pos = 0;
		while (pos < win_fill && win_value[pos] <= v)
			pos++;
		for (i = win_fill; i > pos; i--) begin
			win_value[i] = win_value[i - 1];
			win_slot[i]  = win_slot[i - 1];
		end
		win_value[pos] = v;
		win_slot[pos]  = next_slot;
		win_fill++;
		next_slot = (next_slot + 1) % swmf_pkg::WINDOW;
		// upper median, or the top entry while the window fills
		pick = swmf_pkg::WINDOW / 2;
		if (pick > win_fill - 1)
			pick = win_fill - 1;
		return win_value[pick];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_fill     = 0;
			next_slot    = 0;
			owed_q.delete();
			mismatches   = 0;
			medians_seen = 0;
			medians_owed = 0;
		end else begin
			// median transfer: compare with the oldest prediction
			if (medians.valid && medians.ready) begin
				medians_seen++;
				if (owed_q.size() == 0) begin
					mismatches++;
					$display("%0t: median %h arrived with no sample outstanding",
						$time, medians.median);
				end else begin
					oldest = owed_q.pop_front();
					if (medians.median !== oldest) begin
						mismatches++;
						$display("%0t: median mismatch: expected %h, actual %h",
							$time, oldest, medians.median);
					end
				end
			end
			// sample transfer: predict its median
			if (samples.valid && samples.ready)
				owed_q.push_back(slide_window(samples.sample));
			medians_owed = owed_q.size();
		end
	end

endmodule

@@ verif/sliding_window_median_filter_tb.sv @@
`timescale 1ns / 1ps

module sliding_window_median_filter_tb;

	typedef logic [swmf_pkg::FIELD_BITS-1:0] word_t;

	// shapes of the random sample runs
	typedef enum int unsigned {
		PAT_ANY,
		PAT_FEW,
		PAT_EDGE,
		PAT_UP,
		PAT_DOWN,
		PAT_BAND
	} pattern_t;

	localparam int unsigned ITEMS    = 950;
	localparam int unsigned MAX_IDLE = 17;

	localparam word_t DIRECTED [24] = '{
		16'hFFFF, 16'h0000, 16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'hAAAA, 16'h5555,
		16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0001, 16'hFFFE, 16'h8000,
		16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h1234
	};

	logic clk = 1'b0;
	logic arst_n;

	int mismatches;
	int medians_seen;
	int medians_owed;

	int unsigned sent;
	bit          src_burst;
	bit          snk_burst;

	swmf_sample_if samples_if ();
	swmf_median_if medians_if ();

	sliding_window_median_filter u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples_if),
		.medians (medians_if)
	);

	sliding_window_median_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.samples      (samples_if),
		.medians      (medians_if),
		.mismatches   (mismatches),
		.medians_seen (medians_seen),
		.medians_owed (medians_owed)
	);

	// 12 ns clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// idle cycles ahead of one transfer; bursts run with none at all
	function automatic int unsigned idle_cycles(inout bit burst);
		if ($urandom_range(0, 39) == 0)
			burst = !burst;
		return burst ? 0 : $urandom_range(0, MAX_IDLE);
	endfunction

	// next sample of a run, shaped by its pattern
	function automatic word_t next_value(input pattern_t pattern, input word_t prev);
		word_t v;
		case (pattern)
			PAT_FEW: begin
				v = word_t'($urandom_range(0, 3));
			end
			PAT_EDGE: begin
				case ($urandom_range(0, 3))
					0: v = 16'h0000;
					1: v = 16'hFFFF;
					2: v = 16'h7FFF;
					default: v = 16'h8000;
				endcase
			end
			PAT_UP: begin
				v = prev + word_t'($urandom_range(0, 3));
			end
			PAT_DOWN: begin
				v = prev - word_t'($urandom_range(0, 3));
			end
			PAT_BAND: begin
				v = {prev[swmf_pkg::FIELD_BITS-1:4], 4'($urandom)};
			end
			default: begin
				v = word_t'($urandom);
			end
		endcase
		return v;
	endfunction

	// one sample transfer after a random gap; valid stays up across back-to-back items
	task automatic push_sample(input word_t v);
		int unsigned gap;
		gap = idle_cycles(src_burst);
		if (gap > 0) begin
			samples_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		samples_if.valid  <= 1'b1;
		samples_if.sample <= v;
		do
			@(posedge clk);
		while (!samples_if.ready);
		sent++;
	endtask

	// median receiver with random stalls
	initial begin
		int unsigned stall;
		medians_if.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			stall = idle_cycles(snk_burst);
			if (stall > 0) begin
				medians_if.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			medians_if.ready <= 1'b1;
			do
				@(posedge clk);
			while (!medians_if.valid);
		end
	end

	// stimulus and verdict
	initial begin
		pattern_t    pattern;
		int unsigned run;
		int unsigned k;
		word_t       prev;
		arst_n            = 1'b0;
		samples_if.valid  = 1'b0;
		samples_if.sample = '0;
		sent              = 0;
		src_burst         = 1'b0;
		snk_burst         = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// fill with extremes and ties, then wrap over runs of equal values
		foreach (DIRECTED[i])
			push_sample(DIRECTED[i]);

		// random runs: heavy ties, extremes, monotonic stretches and narrow bands
		prev = word_t'($urandom);
		while (sent < ITEMS) begin
			pattern = pattern_t'($urandom_range(0, PAT_BAND));
			run     = $urandom_range(8, 40);
			for (k = 0; k < run && sent < ITEMS; k++) begin
				prev = next_value(pattern, prev);
				push_sample(prev);
			end
		end
		samples_if.valid <= 1'b0;

		// drain, then leave room for any stray median
		@(posedge clk);
		while (medians_owed != 0)
			@(posedge clk);
		repeat (2 * MAX_IDLE + 4) @(posedge clk);

		$display("%0d samples through a %0d-entry window: fill, wrap, ties, extremes, runs",
			sent, swmf_pkg::WINDOW);
		$display("%0d medians checked, %0d mismatches", medians_seen, mismatches);
		if (mismatches == 0 && medians_owed == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	// watchdog
	initial begin
		#5_000_000;
		$display("%0t: timed out with %0d medians outstanding", $time, medians_owed);
		$display("Regression FAIL");
		$finish;
	end

endmodule

@@ files.f @@
+incdir+design
design/swmf_pkg.sv
design/swmf_if.sv
design/swmf_cell.sv
design/sliding_window_median_filter.sv
design/swmf_checker.sv
verif/sliding_window_median_checker.sv
verif/sliding_window_median_filter_tb.sv
